// File: rtl/kcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyboard/cassette parallel port block.
package kcp_pkg;

    typedef enum logic [2:0] {
        KIND_KEY   = 3'd0,
        KIND_FRAME = 3'd1,
        KIND_PORTC = 3'd2,
        KIND_CTRL  = 3'd3,
        KIND_READ  = 3'd4,
        KIND_SYNC  = 3'd5,
        KIND_LOAD  = 3'd6,
        KIND_SAVE  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        REG_RATIO      = 2'd0,
        REG_IDLE_LIMIT = 2'd1,
        REG_THRESHOLD  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        SEL_PORT_A = 2'd0,
        SEL_PORT_B = 2'd1,
        SEL_PORT_C = 2'd2
    } t_port_sel;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  key_code;
        logic        shift_held;
        logic        ctrl_held;
        logic        func_held;
        logic [7:0]  write_data;
        logic [1:0]  port_select;
        logic [7:0]  tape_byte;
        logic        tape_ok;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        save_sample_valid;
        logic        save_level;
        logic        save_done;
        logic [31:0] saved_count;
        logic        load_running;
        logic        start_accepted;
    } t_result;

    typedef struct packed {
        logic [15:0] ratio;
        logic [31:0] idle_limit;
        logic [7:0]  threshold;
    } t_cfg;

    typedef struct packed {
        logic        save_sample_valid;
        logic        save_level;
        logic        save_done;
        logic [31:0] saved_count;
        logic        load_running;
        logic        start_accepted;
    } t_tape_status;

    localparam logic [6:0]  NO_KEY           = 7'd127;
    localparam logic [6:0]  KEY_LIMIT        = 7'd96;
    // floor(key / 12) = (key * 43) >> 9 for every key below 128
    localparam logic [12:0] ROW_RECIP        = 13'd43;
    localparam int          ROW_SHIFT        = 9;
    localparam logic [2:0]  ROW_FUNC         = 3'd5;
    localparam logic [2:0]  ROW_CTRL_SHIFT   = 3'd6;
    localparam logic [7:0]  CTRL_SAVE_HIGH   = 8'h09;
    localparam logic [7:0]  CTRL_SAVE_LOW    = 8'h08;
    localparam logic [15:0] RATIO_RESET      = 16'd81;
    localparam logic [31:0] IDLE_LIMIT_RESET = 32'd4000000;
    localparam logic [7:0]  THRESHOLD_RESET  = 8'd128;

endpackage

// File: rtl/keyboard_cassette_ppi_interface.sv
`timescale 1ns / 1ps
// Keyboard matrix and cassette port emulation behind a parallel-port register model.
// Each input beat (key event, frame, port C write, control write, port read, sync tick,
// start load, start save) produces exactly one result beat. A beat is captured into an
// input register, processed by the matrix and tape logic, and held in an output register,
// so one beat per clock is sustained while result beats are taken as they are offered;
// while a result waits, the input side takes one more beat into the input register and
// then holds off until the result is taken.
// The three configuration registers (decimation ratio, idle stop limit, load threshold)
// sit at byte addresses 0, 4 and 8 and should be written only while no beat is in flight.
module keyboard_cassette_ppi_interface #(
    parameter int HOLD_FRAMES = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [6:0]  i_key_code,
    input  logic        i_shift_held,
    input  logic        i_ctrl_held,
    input  logic        i_func_held,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_port_select,
    input  logic [7:0]  i_tape_byte,
    input  logic        i_tape_ok,
    // result beats
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_save_sample_valid,
    output logic        o_save_level,
    output logic        o_save_done,
    output logic [31:0] o_saved_count,
    output logic        o_load_running,
    output logic        o_start_accepted,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kcp_pkg::t_cfg         r_cfg;
    logic                  r_in_valid;
    kcp_pkg::t_item        r_in;
    logic                  r_out_valid;
    kcp_pkg::t_result      r_out;

    kcp_pkg::t_item        w_item;
    kcp_pkg::t_result      w_result;
    kcp_pkg::t_tape_status w_tape;
    kcp_pkg::t_reg         w_reg;
    logic                  w_advance;
    logic                  w_fire;
    logic                  w_take;
    logic                  w_cfg_write;
    logic [7:0]            w_port_a;
    logic [6:0]            w_port_b_lo;
    logic [7:0]            w_port_c;
    logic                  w_port_b7;

    // configuration port
    assign pready      = 1'b1;
    assign w_reg       = kcp_pkg::t_reg'(paddr[3:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio      <= kcp_pkg::RATIO_RESET;
            r_cfg.idle_limit <= kcp_pkg::IDLE_LIMIT_RESET;
            r_cfg.threshold  <= kcp_pkg::THRESHOLD_RESET;
        end else if (w_cfg_write) begin
            case (w_reg)
                kcp_pkg::REG_RATIO:      r_cfg.ratio      <= pwdata[15:0];
                kcp_pkg::REG_IDLE_LIMIT: r_cfg.idle_limit <= pwdata;
                kcp_pkg::REG_THRESHOLD:  r_cfg.threshold  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            kcp_pkg::REG_RATIO:      prdata = {16'd0, r_cfg.ratio};
            kcp_pkg::REG_IDLE_LIMIT: prdata = r_cfg.idle_limit;
            kcp_pkg::REG_THRESHOLD:  prdata = {24'd0, r_cfg.threshold};
            default:                 prdata = 32'd0;
        endcase
    end

    // flow control: the input register drains whenever the output register can load
    assign w_advance = !r_out_valid || i_ready;
    assign w_fire    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;
    assign w_take    = i_valid && o_ready;

    assign w_item.kind        = kcp_pkg::t_kind'(i_kind);
    assign w_item.key_code    = i_key_code;
    assign w_item.shift_held  = i_shift_held;
    assign w_item.ctrl_held   = i_ctrl_held;
    assign w_item.func_held   = i_func_held;
    assign w_item.write_data  = i_write_data;
    assign w_item.port_select = i_port_select;
    assign w_item.tape_byte   = i_tape_byte;
    assign w_item.tape_ok     = i_tape_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= w_item;
        end
    end

    kcp_matrix #(
        .HOLD_FRAMES (HOLD_FRAMES)
    ) u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .o_port_a    (w_port_a),
        .o_port_b_lo (w_port_b_lo),
        .o_port_c    (w_port_c)
    );

    kcp_tape u_tape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .o_port_b7 (w_port_b7),
        .o_status  (w_tape)
    );

    always_comb begin
        w_result.read_data = 8'd0;
        if (r_in.kind == kcp_pkg::KIND_READ) begin
            case (kcp_pkg::t_port_sel'(r_in.port_select))
                kcp_pkg::SEL_PORT_A: w_result.read_data = w_port_a;
                kcp_pkg::SEL_PORT_B: w_result.read_data = {w_port_b7, w_port_b_lo};
                kcp_pkg::SEL_PORT_C: w_result.read_data = w_port_c;
                default:             w_result.read_data = 8'd0;
            endcase
        end
        w_result.save_sample_valid = w_tape.save_sample_valid;
        w_result.save_level        = w_tape.save_level;
        w_result.save_done         = w_tape.save_done;
        w_result.saved_count       = w_tape.saved_count;
        w_result.load_running      = w_tape.load_running;
        w_result.start_accepted    = w_tape.start_accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_data         = r_out.read_data;
    assign o_save_sample_valid = r_out.save_sample_valid;
    assign o_save_level        = r_out.save_level;
    assign o_save_done         = r_out.save_done;
    assign o_saved_count       = r_out.saved_count;
    assign o_load_running      = r_out.load_running;
    assign o_start_accepted    = r_out.start_accepted;

    a_level_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.save_level |-> r_out.save_sample_valid)
        else $error("save level high without a sample");

    a_done_excludes_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.save_done |-> !r_out.start_accepted && r_out.read_data == 8'd0)
        else $error("save done on a beat that is not a sync tick");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("stalled input beat lost");

endmodule

// File: rtl/kcp_matrix.sv
`timescale 1ns / 1ps
// Keyboard hold state and the port A/B/C matrix scan registers.
module kcp_matrix #(
    parameter int HOLD_FRAMES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  kcp_pkg::t_item    i_item,
    output logic [7:0]        o_port_a,
    output logic [6:0]        o_port_b_lo,
    output logic [7:0]        o_port_c
);

    localparam logic [1:0] HOLD_INIT = 2'(HOLD_FRAMES);

    logic [6:0]  r_held_key, n_held_key;
    logic        r_shift, n_shift;
    logic        r_ctrl, n_ctrl;
    logic        r_func, n_func;
    logic [1:0]  r_hold, n_hold;
    logic [7:0]  r_port_a, n_port_a;
    logic [6:0]  r_port_b_lo, n_port_b_lo;
    logic [7:0]  r_port_c, n_port_c;

    logic [12:0] w_prod;
    logic [2:0]  w_key_row;
    logic [6:0]  w_row_base;
    logic [3:0]  w_key_col;
    logic [2:0]  w_scan_row;
    logic        w_key_hit;

    assign w_prod     = 13'(r_held_key) * kcp_pkg::ROW_RECIP;
    assign w_key_row  = w_prod[kcp_pkg::ROW_SHIFT +: 3];
    assign w_row_base = 7'({w_key_row, 3'b000}) + 7'({w_key_row, 2'b00});
    assign w_key_col  = 4'(r_held_key - w_row_base);
    assign w_scan_row = i_item.write_data[2:0];
    assign w_key_hit  = (r_held_key < kcp_pkg::KEY_LIMIT) && (w_key_row == w_scan_row);

    always_comb begin
        n_held_key  = r_held_key;
        n_shift     = r_shift;
        n_ctrl      = r_ctrl;
        n_func      = r_func;
        n_hold      = r_hold;
        n_port_a    = r_port_a;
        n_port_b_lo = r_port_b_lo;
        n_port_c    = r_port_c;
        case (i_item.kind)
            kcp_pkg::KIND_KEY: begin
                n_held_key = i_item.key_code;
                n_shift    = i_item.shift_held;
                n_ctrl     = i_item.ctrl_held;
                n_func     = i_item.func_held;
                n_hold     = HOLD_INIT;
            end
            kcp_pkg::KIND_FRAME: begin
                if (r_hold != 2'd0) begin
                    n_hold = r_hold - 2'd1;
                end else begin
                    n_held_key = kcp_pkg::NO_KEY;
                    n_shift    = 1'b0;
                    n_ctrl     = 1'b0;
                    n_func     = 1'b0;
                end
            end
            kcp_pkg::KIND_PORTC: begin
                n_port_c    = i_item.write_data;
                n_port_a    = 8'hFF;
                n_port_b_lo = 7'h7F;
                if (w_key_hit) begin
                    if (!w_key_col[3]) begin
                        n_port_a[w_key_col[2:0]] = 1'b0;
                    end else begin
                        n_port_b_lo[w_key_col[1:0]] = 1'b0;
                    end
                end
                // modifiers sit in fixed matrix positions
                if (w_scan_row == kcp_pkg::ROW_FUNC && r_func) begin
                    n_port_b_lo[3] = 1'b0;
                end
                if (w_scan_row == kcp_pkg::ROW_CTRL_SHIFT && r_ctrl) begin
                    n_port_b_lo[2] = 1'b0;
                end
                if (w_scan_row == kcp_pkg::ROW_CTRL_SHIFT && r_shift) begin
                    n_port_b_lo[3] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key  <= kcp_pkg::NO_KEY;
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_func      <= 1'b0;
            r_hold      <= 2'd0;
            r_port_a    <= 8'hFF;
            r_port_b_lo <= 7'h7F;
            r_port_c    <= 8'hFF;
        end else if (i_fire) begin
            r_held_key  <= n_held_key;
            r_shift     <= n_shift;
            r_ctrl      <= n_ctrl;
            r_func      <= n_func;
            r_hold      <= n_hold;
            r_port_a    <= n_port_a;
            r_port_b_lo <= n_port_b_lo;
            r_port_c    <= n_port_c;
        end
    end

    assign o_port_a    = r_port_a;
    assign o_port_b_lo = r_port_b_lo;
    assign o_port_c    = r_port_c;

endmodule

// File: rtl/kcp_tape.sv
`timescale 1ns / 1ps
// Cassette load and save sequencing driven by sync ticks.
module kcp_tape (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  kcp_pkg::t_item        i_item,
    input  kcp_pkg::t_cfg         i_cfg,
    output logic                  o_port_b7,
    output kcp_pkg::t_tape_status o_status
);

    logic [7:0]  r_control, n_control;
    logic        r_load_active, n_load_active;
    logic [15:0] r_load_phase, n_load_phase;
    logic [7:0]  r_tape_sample, n_tape_sample;
    logic        r_port_b7, n_port_b7;
    logic        r_save_active, n_save_active;
    logic [15:0] r_save_phase, n_save_phase;
    logic [31:0] r_total, n_total;
    logic [31:0] r_idle, n_idle;
    logic        r_high_seen, n_high_seen;

    logic [16:0] w_load_sum;
    logic [16:0] w_save_sum;
    logic        w_load_due;
    logic        w_save_due;
    logic        w_valid, w_level, w_done, w_accepted;

    assign w_load_sum = {1'b0, r_load_phase} + 17'd1;
    assign w_save_sum = {1'b0, r_save_phase} + 17'd1;
    assign w_load_due = w_load_sum >= {1'b0, i_cfg.ratio};
    assign w_save_due = w_save_sum >= {1'b0, i_cfg.ratio};

    always_comb begin
        n_control     = r_control;
        n_load_active = r_load_active;
        n_load_phase  = r_load_phase;
        n_tape_sample = r_tape_sample;
        n_port_b7     = r_port_b7;
        n_save_active = r_save_active;
        n_save_phase  = r_save_phase;
        n_total       = r_total;
        n_idle        = r_idle;
        n_high_seen   = r_high_seen;
        w_valid       = 1'b0;
        w_level       = 1'b0;
        w_done        = 1'b0;
        w_accepted    = 1'b0;
        case (i_item.kind)
            kcp_pkg::KIND_PORTC: begin
                // a row scan rebuilds port B with bit 7 high
                n_port_b7 = 1'b1;
            end
            kcp_pkg::KIND_CTRL: begin
                n_control = i_item.write_data;
            end
            kcp_pkg::KIND_SYNC: begin
                if (r_load_active) begin
                    if (w_load_due) begin
                        n_load_phase = 16'd0;
                        if (i_item.tape_ok) begin
                            n_tape_sample = i_item.tape_byte;
                        end else begin
                            n_load_active = 1'b0;
                            n_tape_sample = 8'd0;
                        end
                    end else begin
                        n_load_phase = w_load_sum[15:0];
                    end
                    n_port_b7 = n_tape_sample > i_cfg.threshold;
                end
                if (r_save_active) begin
                    if (r_control == kcp_pkg::CTRL_SAVE_HIGH) begin
                        if (w_save_due) begin
                            n_save_phase = 16'd0;
                            n_total      = r_total + 32'd1;
                            w_valid      = 1'b1;
                            w_level      = 1'b1;
                        end else begin
                            n_save_phase = w_save_sum[15:0];
                        end
                        n_idle      = 32'd0;
                        n_high_seen = 1'b1;
                    end else if (r_control == kcp_pkg::CTRL_SAVE_LOW && r_high_seen) begin
                        if (w_save_due) begin
                            n_save_phase = 16'd0;
                            n_total      = r_total + 32'd1;
                            w_valid      = 1'b1;
                        end else begin
                            n_save_phase = w_save_sum[15:0];
                        end
                        // saturate the idle count
                        if (r_idle != 32'hFFFF_FFFF) begin
                            n_idle = r_idle + 32'd1;
                        end
                        if (n_idle > i_cfg.idle_limit) begin
                            n_save_active = 1'b0;
                            n_high_seen   = 1'b0;
                            w_done        = 1'b1;
                        end
                    end
                end
            end
            kcp_pkg::KIND_LOAD: begin
                if (!r_load_active) begin
                    n_load_active = 1'b1;
                    w_accepted    = 1'b1;
                end
            end
            kcp_pkg::KIND_SAVE: begin
                if (!r_save_active) begin
                    n_save_active = 1'b1;
                    n_total       = 32'd0;
                    w_accepted    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control     <= 8'd0;
            r_load_active <= 1'b0;
            r_load_phase  <= 16'd0;
            r_tape_sample <= 8'd0;
            r_port_b7     <= 1'b0;
            r_save_active <= 1'b0;
            r_save_phase  <= 16'd0;
            r_total       <= 32'd0;
            r_idle        <= 32'd0;
            r_high_seen   <= 1'b0;
        end else if (i_fire) begin
            r_control     <= n_control;
            r_load_active <= n_load_active;
            r_load_phase  <= n_load_phase;
            r_tape_sample <= n_tape_sample;
            r_port_b7     <= n_port_b7;
            r_save_active <= n_save_active;
            r_save_phase  <= n_save_phase;
            r_total       <= n_total;
            r_idle        <= n_idle;
            r_high_seen   <= n_high_seen;
        end
    end

    assign o_port_b7                  = r_port_b7;
    assign o_status.save_sample_valid = w_valid;
    assign o_status.save_level        = w_level;
    assign o_status.save_done         = w_done;
    assign o_status.saved_count       = n_total;
    assign o_status.load_running      = n_load_active;
    assign o_status.start_accepted    = w_accepted;

endmodule
